// ===== rtl/core/rlmts_pkg.sv =====
// Shared types, widths and helpers for the run-length mean-threshold segmenter.
package rlmts_pkg;

  localparam int LEN_W  = 31;               // run length and positions
  localparam int MAG_W  = 24;               // unsigned Q8.16 magnitude
  localparam int POS_W  = 31;
  localparam int CUR_W  = 32;               // cursor and open length
  localparam int PROD_W = MAG_W + LEN_W;    // magnitude times run length
  localparam int SUM_W  = 64;               // saturating weighted sum
  localparam int THR_W  = MAG_W + CUR_W;    // threshold times open length
  localparam int CFG_W  = 31;               // widest config register
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAGNITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

  localparam logic [MAG_W-1:0] MIN_MAGNITUDE_RST = 24'd65536;
  localparam logic [LEN_W-1:0] MIN_LENGTH_RST    = '0;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST    = '1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [LEN_W-1:0] run_length;
    logic [MAG_W-1:0] magnitude;
    logic [POS_W-1:0] region_start;
    logic             first_of_region;
    logic             last_of_region;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] seg_start;
    logic [POS_W-1:0] seg_end;
    logic             last_of_burst;
  } out_item_t;

  // Registered run with its products precomputed.
  typedef struct packed {
    in_item_t          item;
    logic [PROD_W-1:0] contrib;   // magnitude * run_length
    logic [PROD_W-1:0] thr_run;   // min_magnitude * run_length
    logic              mag_ge;    // magnitude >= min_magnitude
  } run_t;

  // Up to two results of one run, packed toward item0.
  typedef struct packed {
    logic      valid0;
    logic      valid1;
    out_item_t item0;
    out_item_t item1;
  } res_pair_t;

  typedef struct packed {
    logic [MAG_W-1:0] min_magnitude;
    logic [LEN_W-1:0] min_length;
    logic [LEN_W-1:0] max_length;
  } cfg_t;

  // Segment length accepted when (len - 1) lies in [lo, hi].
  function automatic logic len_ok(input logic [CUR_W-1:0] len,
                                  input logic [LEN_W-1:0] lo,
                                  input logic [LEN_W-1:0] hi);
    logic [CUR_W-1:0] lm1;
    lm1 = len - CUR_W'(1);
    return (len != '0) && (lm1 >= {1'b0, lo}) && (lm1 <= {1'b0, hi});
  endfunction

endpackage

// ===== rtl/core/rlmts_prep.sv =====
// Input register stage: accept a run and register its two products.
module rlmts_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rlmts_pkg::in_item_t in_data,
  input  logic [23:0]       min_magnitude,
  input  logic              room,
  output logic              fire,
  output rlmts_pkg::run_t   run
);
  import rlmts_pkg::*;

  logic  run_valid_r, run_valid_nxt;
  run_t  run_r, run_nxt;
  logic  accept;

  assign fire     = run_valid_r && room;
  assign in_stall = run_valid_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    run_nxt.item    = in_data;
    run_nxt.contrib = PROD_W'(in_data.magnitude) * PROD_W'(in_data.run_length);
    run_nxt.thr_run = PROD_W'(min_magnitude) * PROD_W'(in_data.run_length);
    run_nxt.mag_ge  = in_data.magnitude >= min_magnitude;
    run_valid_nxt   = accept ? 1'b1 : (fire ? 1'b0 : run_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
    end else begin
      run_valid_r <= run_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run_r <= run_nxt;
    end
  end

  assign run = run_r;

endmodule

// ===== rtl/core/rlmts_core.sv =====
// Segment state and the per-run extend, open and close decision.
module rlmts_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  rlmts_pkg::run_t     run,
  input  rlmts_pkg::cfg_t     cfg,
  output rlmts_pkg::res_pair_t res
);
  import rlmts_pkg::*;

  logic              in_seg_r,  in_seg_nxt;
  logic [CUR_W-1:0]  start_r,   start_nxt;
  logic [CUR_W-1:0]  cursor_r,  cursor_nxt;
  logic [SUM_W-1:0]  wsum_r,    wsum_nxt;
  logic [CUR_W-1:0]  olen_r,    olen_nxt;
  logic [THR_W-1:0]  thr_r,     thr_nxt;   // min_magnitude * olen_r

  logic              in_seg_e;
  logic [CUR_W-1:0]  start_e, cursor_e, olen_e;
  logic [SUM_W-1:0]  wsum_e;
  logic [THR_W-1:0]  thr_e, thr_sat, thr_ext, thr_f;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  new_sum, wsum_f;
  logic [THR_W:0]    thr_cmp;
  logic [CUR_W:0]    olen_wide;
  logic [CUR_W-1:0]  olen_ext, olen_f, start_f;
  logic              pass, extend, open, seg_f, close_b, keep_a, keep_b;
  out_item_t         res_a, res_b;

  always_comb begin
    // A new region drops any open segment and reloads the cursor.
    if (run.item.first_of_region) begin
      in_seg_e = 1'b0;
      start_e  = '0;
      cursor_e = {1'b0, run.item.region_start};
      wsum_e   = '0;
      olen_e   = '0;
      thr_e    = '0;
    end else begin
      in_seg_e = in_seg_r;
      start_e  = start_r;
      cursor_e = cursor_r;
      wsum_e   = wsum_r;
      olen_e   = olen_r;
      thr_e    = thr_r;
    end

    sum_wide  = {1'b0, wsum_e} + (SUM_W+1)'(run.contrib);
    new_sum   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    thr_cmp   = {1'b0, thr_e} + (THR_W+1)'(run.thr_run);
    pass      = new_sum >= SUM_W'(thr_cmp);

    // Saturate the open length; the threshold product follows it.
    olen_wide = {1'b0, olen_e} + (CUR_W+1)'(run.item.run_length);
    thr_sat   = {cfg.min_magnitude, {CUR_W{1'b0}}} - THR_W'(cfg.min_magnitude);
    olen_ext  = olen_wide[CUR_W] ? '1 : olen_wide[CUR_W-1:0];
    thr_ext   = olen_wide[CUR_W] ? thr_sat : thr_cmp[THR_W-1:0];

    extend    = in_seg_e && pass;
    open      = !extend && run.mag_ge;
    seg_f     = extend || open;
    start_f   = extend ? start_e : cursor_e;
    olen_f    = extend ? olen_ext : (seg_f ? CUR_W'(run.item.run_length) : '0);
    wsum_f    = extend ? new_sum : (seg_f ? SUM_W'(run.contrib) : '0);
    thr_f     = extend ? thr_ext : (seg_f ? THR_W'(run.thr_run) : '0);
    cursor_nxt = cursor_e + CUR_W'(run.item.run_length);

    keep_a  = in_seg_e && !pass && len_ok(olen_e, cfg.min_length, cfg.max_length);
    close_b = run.item.last_of_region && seg_f;
    keep_b  = close_b && len_ok(olen_f, cfg.min_length, cfg.max_length);

    res_a.seg_start     = start_e[POS_W-1:0];
    res_a.seg_end       = cursor_e[POS_W-1:0];
    res_a.last_of_burst = !keep_b;
    res_b.seg_start     = start_f[POS_W-1:0];
    res_b.seg_end       = cursor_nxt[POS_W-1:0];
    res_b.last_of_burst = 1'b1;

    res.valid0 = fire && (keep_a || keep_b);
    res.valid1 = fire && keep_a && keep_b;
    res.item0  = keep_a ? res_a : res_b;
    res.item1  = res_b;

    if (fire) begin
      in_seg_nxt = seg_f && !close_b;
      start_nxt  = start_f;
      wsum_nxt   = close_b ? '0 : wsum_f;
      olen_nxt   = close_b ? '0 : olen_f;
      thr_nxt    = close_b ? '0 : thr_f;
    end else begin
      // Idle: rebuild the threshold product in case min_magnitude changed.
      in_seg_nxt = in_seg_r;
      start_nxt  = start_r;
      cursor_nxt = cursor_r;
      wsum_nxt   = wsum_r;
      olen_nxt   = olen_r;
      thr_nxt    = THR_W'(cfg.min_magnitude) * THR_W'(olen_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seg_r <= 1'b0;
      start_r  <= '0;
      cursor_r <= '0;
      wsum_r   <= '0;
      olen_r   <= '0;
      thr_r    <= '0;
    end else begin
      in_seg_r <= in_seg_nxt;
      start_r  <= start_nxt;
      cursor_r <= cursor_nxt;
      wsum_r   <= wsum_nxt;
      olen_r   <= olen_nxt;
      thr_r    <= thr_nxt;
    end
  end

endmodule

// ===== rtl/core/rlmts_outq.sv =====
// Result queue: up to two results in a cycle, one beat out unless stalled.
module rlmts_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlmts_pkg::res_pair_t res,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rlmts_pkg::out_item_t out_data
);
  import rlmts_pkg::*;

  out_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [QPTR_W:0]    count_r, count_nxt;
  logic [1:0]         push_n;
  logic               pop;

  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = count_r <= (QPTR_W+1)'(QDEPTH - 2);
  assign pop       = out_valid && !out_stall;
  assign push_n    = {1'b0, res.valid0} + {1'b0, res.valid1};
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid0) begin
      mem_r[wr_ptr_r] <= res.item0;
    end
    if (res.valid1) begin
      mem_r[wr_ptr_p1] <= res.item1;
    end
  end

endmodule

// ===== rtl/core/run_length_mean_threshold_segmenter.sv =====
// Top level of the run-length mean-threshold segmenter.
//
// Input channel (in_valid / in_stall / in_data): one run-length beat per
// run of a region, in order, flagged first_of_region / last_of_region.
// Output channel (out_valid / out_stall / out_data): closed segments whose
// length minus one lies in [min_length, max_length]. A run yields zero, one
// or two segments; last_of_burst marks the final one caused by that run.
// Config port (cfg_we / cfg_index / cfg_wdata): index 0 min_magnitude,
// 1 min_length, 2 max_length; other indexes are ignored. Write only while
// the block is idle.
//
// Throughput: one run per cycle while the result queue has room. The mean
// test keeps a running product of threshold and open length, so each run
// costs one add-and-compare in the state stage. The prep stage registers
// the run beat and the four-entry queue its results, draining one beat per
// cycle while out_stall is low; a run closing two segments uses two beats.
//
// Reset (rst_n low, synchronous) closes any segment, zeroes the cursor and
// loads the register defaults. When the receiver stalls, the queue fills
// and in_stall rises while a run waits and fewer than two entries are free.
module run_length_mean_threshold_segmenter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rlmts_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rlmts_pkg::out_item_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [rlmts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rlmts_pkg::CFG_W-1:0]          cfg_wdata
);
  import rlmts_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  run_t      run;
  res_pair_t res;
  logic      room;
  logic      fire;

  // Config registers: update the addressed one, hold the rest.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_MAGNITUDE: cfg_nxt.min_magnitude = cfg_wdata[MAG_W-1:0];
        CFG_MIN_LENGTH:    cfg_nxt.min_length    = cfg_wdata[LEN_W-1:0];
        CFG_MAX_LENGTH:    cfg_nxt.max_length    = cfg_wdata[LEN_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_magnitude <= MIN_MAGNITUDE_RST;
      cfg_r.min_length    <= MIN_LENGTH_RST;
      cfg_r.max_length    <= MAX_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register the run beat together with both products.
  rlmts_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .min_magnitude (cfg_r.min_magnitude),
    .room          (room),
    .fire          (fire),
    .run           (run)
  );

  // Advance the segment state; emit closed segments.
  rlmts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .run   (run),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Hold results until the receiver takes them.
  rlmts_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/rlmts_checker.sv =====
// Port-level checker for the segmenter, bound to the top level.
module rlmts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input rlmts_pkg::in_item_t             in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input rlmts_pkg::out_item_t            out_data,
  input logic                            cfg_we,
  input logic [rlmts_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [rlmts_pkg::CFG_W-1:0]     cfg_wdata
);
  import rlmts_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backpressure only comes from a backed-up result queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result queue");

  // A result appearing on an empty output was caused by an earlier accepted run beat.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding run beat");

endmodule

bind run_length_mean_threshold_segmenter rlmts_checker u_rlmts_checker (.*);
